@@ rtl/rgs_pkg.sv @@
package rgs_pkg;

  localparam int ID_W = 48;
  localparam int CID_W = 11;
  localparam int BASE_W = 8;
  localparam logic [BASE_W-1:0] BASE_RESET = 8'd4;

  typedef enum logic [2:0] {
    OC_ADVANCED   = 3'd0,
    OC_GAP_FILLED = 3'd1,
    OC_SEEN       = 3'd2,
    OC_TOO_FAR    = 3'd3,
    OC_BAD_CLIENT = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [CID_W-1:0] client;
    logic [ID_W-1:0]  req_seq;
  } in_item_t;

  typedef struct packed {
    logic            accepted;
    outcome_t        outcome;
    logic [ID_W-1:0] low_mark_out;
  } out_item_t;

endpackage

@@ rtl/rgs_ram.sv @@
module rgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rgs_front.sv @@
module rgs_front #(
  parameter int CLIENT_COUNT = 64,
  localparam int CIW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  rgs_pkg::in_item_t         in_item,
  input  logic                      cfg_we,
  input  logic [rgs_pkg::BASE_W-1:0] cfg_data,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output logic                      cmd_bad,
  output logic [CIW-1:0]            cmd_idx,
  output logic [rgs_pkg::ID_W-1:0]  cmd_rid
);
  import rgs_pkg::*;

  logic [BASE_W-1:0] base_r;
  logic              q_bad_r [2];
  logic [CIW-1:0]    q_idx_r [2];
  logic [ID_W-1:0]   q_rid_r [2];
  logic              wp_r;
  logic              rp_r;
  logic [1:0]        cnt_r;

  logic             push;
  logic             pop;
  logic [CID_W-1:0] diff;
  logic             bad;

  // classify the client against the configured base
  always_comb begin
    diff = in_item.client - CID_W'(base_r);
    bad  = (in_item.client < CID_W'(base_r)) || (diff >= CID_W'(CLIENT_COUNT));
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push      = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_bad   = q_bad_r[rp_r];
  assign cmd_idx   = q_idx_r[rp_r];
  assign cmd_rid   = q_rid_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_data;
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_bad_r[wp_r] <= bad;
      q_idx_r[wp_r] <= diff[CIW-1:0];
      q_rid_r[wp_r] <= in_item.req_seq;
    end
  end

endmodule

@@ rtl/rgs_back.sv @@
module rgs_back #(
  parameter int CLIENT_COUNT = 64,
  parameter int WINDOW = 256,
  localparam int CIW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic                     cmd_bad,
  input  logic [CIW-1:0]           cmd_idx,
  input  logic [rgs_pkg::ID_W-1:0] cmd_rid,
  output logic                     out_valid,
  input  logic                     out_pop,
  output rgs_pkg::out_item_t       out_item
);
  import rgs_pkg::*;

  localparam int WORD   = (WINDOW < 64) ? WINDOW : 64;
  localparam int WPR    = WINDOW / WORD;
  localparam int OW     = $clog2(WORD);
  localparam int SW     = $clog2(WINDOW);
  localparam int WPW    = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int WSH    = $clog2(WPR);
  localparam int BDEPTH = CLIENT_COUNT * WPR;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CW     = $clog2(WPR + 1);
  localparam int TW     = 2 * ID_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TRD, S_CLS, S_MRD, S_MWR, S_GCK, S_SRD, S_SCK
  } state_t;

  state_t          state_r, state_nxt;
  logic [CIW-1:0]  idx_r, idx_nxt;
  logic [ID_W-1:0] rid_r, rid_nxt;
  logic [ID_W-1:0] hi_r, hi_nxt;
  logic [ID_W-1:0] lo_r, lo_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [SW-1:0]   s0_r, s0_nxt;
  logic [SW-1:0]   rem_r, rem_nxt;
  logic [WPW-1:0]  sw_r, sw_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [BAW-1:0]  clr_r, clr_nxt;
  out_item_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            bm_we, bm_re;
  logic [BAW-1:0]  bm_waddr, bm_raddr;
  logic [WORD-1:0] bm_wdata, bm_rdata;
  logic            tb_we, tb_re;
  logic [CIW-1:0]  tb_waddr, tb_raddr;
  logic [TW-1:0]   tb_wdata, tb_rdata;

  logic            finish;
  out_item_t       res;
  logic            out_free;

  logic [ID_W-1:0] dlo, lo_new, newlow;
  logic [SW-1:0]   gap, s_hit, d;
  logic [SW:0]     avail, k, b_ext, rem_ext;
  logic [WORD-1:0] mask, hits;
  logic [OW-1:0]   p;
  logic            found;

  function automatic logic [WPW-1:0] word_of(input logic [SW-1:0] s);
    return WPW'(s >> OW);
  endfunction

  function automatic logic [BAW-1:0] addr_of(input logic [CIW-1:0] i, input logic [WPW-1:0] w);
    return (BAW'(i) << WSH) | BAW'(w);
  endfunction

  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rid_nxt       = rid_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    slot_nxt      = slot_r;
    s0_nxt        = s0_r;
    rem_nxt       = rem_r;
    sw_nxt        = sw_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    cmd_ready     = 1'b0;
    finish        = 1'b0;
    res           = '0;
    bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0; bm_re = 1'b0; bm_raddr = '0;
    tb_we = 1'b0; tb_waddr = '0; tb_wdata = '0; tb_re = 1'b0; tb_raddr = '0;

    dlo     = rid_r - lo_r;
    lo_new  = ((lo_r + ID_W'(1)) == rid_r) ? rid_r : lo_r;
    gap     = SW'(rid_r - hi_r - ID_W'(1));
    b_ext   = (SW+1)'(slot_r[OW-1:0]);
    avail   = (SW+1)'(WORD) - b_ext;
    rem_ext = (SW+1)'(rem_r);
    k       = (rem_ext < avail) ? rem_ext : avail;
    for (int j = 0; j < WORD; j++) begin
      mask[j] = ((SW+1)'(j) >= b_ext) && ((SW+1)'(j) < (b_ext + k));
    end

    for (int j = 0; j < WORD; j++) begin
      if (cnt_r == '0) begin
        hits[j] = bm_rdata[j] && (OW'(j) >= s0_r[OW-1:0]);
      end else if (cnt_r == CW'(WPR)) begin
        hits[j] = bm_rdata[j] && (OW'(j) < s0_r[OW-1:0]);
      end else begin
        hits[j] = bm_rdata[j];
      end
    end
    found = |hits;
    p     = '0;
    for (int j = WORD - 1; j >= 0; j--) begin
      if (hits[j]) begin
        p = OW'(j);
      end
    end
    s_hit  = (SW'(sw_r) << OW) | SW'(p);
    d      = s_hit - s0_r;
    newlow = lo_r + ID_W'(d);

    unique case (state_r)
      S_INIT: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        if ({1'b0, clr_r} < (BAW+1)'(CLIENT_COUNT)) begin
          tb_we    = 1'b1;
          tb_waddr = CIW'(clr_r);
        end
        if (clr_r == BAW'(BDEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + BAW'(1);
        end
      end
      S_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          idx_nxt = cmd_idx;
          rid_nxt = cmd_rid;
          if (cmd_bad) begin
            finish = 1'b1;
            res    = '{accepted: 1'b0, outcome: OC_BAD_CLIENT, low_mark_out: '0};
          end else begin
            tb_re     = 1'b1;
            tb_raddr  = cmd_idx;
            state_nxt = S_TRD;
          end
        end
      end
      S_TRD: begin
        hi_nxt    = tb_rdata[TW-1:ID_W];
        lo_nxt    = tb_rdata[ID_W-1:0];
        state_nxt = S_CLS;
      end
      S_CLS: begin
        priority if (rid_r > hi_r && dlo < ID_W'(WINDOW)) begin
          // advance: record the new highest, mark the skipped ids
          tb_we    = 1'b1;
          tb_waddr = idx_r;
          tb_wdata = {rid_r, lo_new};
          lo_nxt   = lo_new;
          if (gap == '0) begin
            finish    = 1'b1;
            res       = '{accepted: 1'b1, outcome: OC_ADVANCED, low_mark_out: lo_new};
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = gap;
            slot_nxt  = hi_r[SW-1:0] + SW'(1);
            state_nxt = S_MRD;
          end
        end else if (rid_r > lo_r && rid_r < hi_r) begin
          bm_re     = 1'b1;
          bm_raddr  = addr_of(idx_r, word_of(rid_r[SW-1:0]));
          state_nxt = S_GCK;
        end else if (rid_r <= hi_r) begin
          finish    = 1'b1;
          res       = '{accepted: 1'b1, outcome: OC_SEEN, low_mark_out: lo_r};
          state_nxt = S_IDLE;
        end else begin
          finish    = 1'b1;
          res       = '{accepted: 1'b0, outcome: OC_TOO_FAR, low_mark_out: lo_r};
          state_nxt = S_IDLE;
        end
      end
      S_MRD: begin
        bm_re     = 1'b1;
        bm_raddr  = addr_of(idx_r, word_of(slot_r));
        state_nxt = S_MWR;
      end
      S_MWR: begin
        bm_we    = 1'b1;
        bm_waddr = addr_of(idx_r, word_of(slot_r));
        bm_wdata = bm_rdata | mask;
        rem_nxt  = rem_r - SW'(k);
        slot_nxt = slot_r + SW'(k);
        if (rem_ext == k) begin
          finish    = 1'b1;
          res       = '{accepted: 1'b1, outcome: OC_ADVANCED, low_mark_out: lo_r};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_GCK: begin
        if (bm_rdata[rid_r[OW-1:0]]) begin
          // clear the filled id, then search for the oldest id still missing
          bm_we     = 1'b1;
          bm_waddr  = addr_of(idx_r, word_of(rid_r[SW-1:0]));
          bm_wdata  = bm_rdata & ~(WORD'(1) << rid_r[OW-1:0]);
          s0_nxt    = lo_r[SW-1:0] + SW'(1);
          sw_nxt    = word_of(lo_r[SW-1:0] + SW'(1));
          cnt_nxt   = '0;
          state_nxt = S_SRD;
        end else begin
          finish    = 1'b1;
          res       = '{accepted: 1'b1, outcome: OC_SEEN, low_mark_out: lo_r};
          state_nxt = S_IDLE;
        end
      end
      S_SRD: begin
        bm_re     = 1'b1;
        bm_raddr  = addr_of(idx_r, sw_r);
        state_nxt = S_SCK;
      end
      S_SCK: begin
        if (found || cnt_r == CW'(WPR)) begin
          tb_we     = 1'b1;
          tb_waddr  = idx_r;
          tb_wdata  = {hi_r, found ? newlow : hi_r};
          finish    = 1'b1;
          res       = '{accepted: 1'b1, outcome: OC_GAP_FILLED,
                        low_mark_out: found ? newlow : hi_r};
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          sw_nxt    = (sw_r == WPW'(WPR - 1)) ? '0 : sw_r + WPW'(1);
          state_nxt = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (finish) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r  <= idx_nxt;
    rid_r  <= rid_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    slot_r <= slot_nxt;
    s0_r   <= s0_nxt;
    rem_r  <= rem_nxt;
    sw_r   <= sw_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  rgs_ram #(.WIDTH(WORD), .DEPTH(BDEPTH)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
  );

  rgs_ram #(.WIDTH(TW), .DEPTH(CLIENT_COUNT)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .re(tb_re), .raddr(tb_raddr), .rdata(tb_rdata)
  );

  a_acc_matches_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.accepted ==
      (out_r.outcome != OC_TOO_FAR && out_r.outcome != OC_BAD_CLIENT)))
    else $error("accepted flag disagrees with outcome");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_valid_r || out_pop))
    else $error("result overwrites a waiting item");

  a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR) |-> (rem_r != '0))
    else $error("mark pass with nothing left to mark");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCK) |-> (cnt_r <= CW'(WPR)))
    else $error("gap search ran past the row");

endmodule

@@ rtl/request_gap_scoreboard_top.sv @@
// Channel   Direction  Ports                        Moves
// input     in         in_push / in_full / in_item  one request item (client, request id)
// result    out        out_pop / out_empty / out_item  one verdict item with low mark
// config    in         cfg_we / cfg_data            client base register
//
// Engine work per item: a bad client is answered from idle; already seen or too far is
// decided after the table read, with a bitmap bit read first when the id sits inside
// the window; advance marks each skipped bitmap word (a word is min(WINDOW,64) bits) by
// read and write; gap fill clears the bit, then scans words by read and check, at most
// max(WINDOW/64,1)+1 words. After reset a clearing pass zeroes both RAMs; items queue
// meanwhile. A held result stalls the engine; a two-entry queue takes input.
module request_gap_scoreboard_top #(
  parameter int CLIENT_COUNT = 64,
  parameter int WINDOW = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  rgs_pkg::in_item_t           in_item,
  output logic                        out_empty,
  input  logic                        out_pop,
  output rgs_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [rgs_pkg::BASE_W-1:0]  cfg_data
);
  import rgs_pkg::*;

  localparam int CIW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;

  logic            cmd_valid;
  logic            cmd_ready;
  logic            cmd_bad;
  logic [CIW-1:0]  cmd_idx;
  logic [ID_W-1:0] cmd_rid;
  logic            out_valid;

  // front: hold the client base, classify the client, buffer the item
  rgs_front #(.CLIENT_COUNT(CLIENT_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_bad(cmd_bad), .cmd_idx(cmd_idx), .cmd_rid(cmd_rid)
  );

  // back: table lookup, range marking and gap search over the bitmap
  rgs_back #(.CLIENT_COUNT(CLIENT_COUNT), .WINDOW(WINDOW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_bad(cmd_bad), .cmd_idx(cmd_idx), .cmd_rid(cmd_rid),
    .out_valid(out_valid), .out_pop(out_pop), .out_item(out_item)
  );

  assign out_empty = !out_valid;

endmodule
